@@ rtl/pid_with_integral_window_assert.svh @@
// Assertion macros for the PID controller with integral window
`ifndef PID_WITH_INTEGRAL_WINDOW_ASSERT_SVH
`define PID_WITH_INTEGRAL_WINDOW_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIDW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidw assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PIDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidw assertion failed");

`endif

@@ rtl/pidw_pkg.sv @@
// Types and codes shared by the PID controller with integral window
`timescale 1ns / 1ps
`default_nettype none
package pidw_pkg;

  typedef struct packed {
    logic signed [31:0] sample;
    logic signed [31:0] setpoint;
    logic               enable;
  } pidw_in_t;

  typedef struct packed {
    logic signed [15:0] motor_drive;
    logic signed [31:0] error_value;
  } pidw_out_t;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic        [30:0] integral_window;
    logic signed [15:0] drive_max;
    logic signed [15:0] drive_min;
    logic signed [15:0] sensor_scale;
    logic signed [15:0] motor_scale;
  } pidw_cfg_t;

  typedef enum logic [2:0] {
    CFG_KP           = 3'd0,
    CFG_KI           = 3'd1,
    CFG_KD           = 3'd2,
    CFG_WINDOW       = 3'd3,
    CFG_DRIVE_MAX    = 3'd4,
    CFG_DRIVE_MIN    = 3'd5,
    CFG_SENSOR_SCALE = 3'd6,
    CFG_MOTOR_SCALE  = 3'd7
  } pidw_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ERR,
    ST_PROP,
    ST_DERIV,
    ST_INT_LO,
    ST_INT_HI,
    ST_SUM,
    ST_CLAMP,
    ST_MOTOR,
    ST_OUT
  } pidw_state_t;

  typedef enum logic [2:0] {
    MUL_SCALE,
    MUL_PROP,
    MUL_DERIV,
    MUL_INT_LO,
    MUL_INT_HI,
    MUL_MOTOR
  } pidw_mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_ADD_HI
  } pidw_acc_op_t;

  typedef struct packed {
    logic          ld_in;
    logic          clr_state;
    logic          mul_en;
    pidw_mul_sel_t mul_sel;
    logic          ld_err;
    pidw_acc_op_t  acc_op;
    logic          ld_drive;
    logic          ld_out;
  } pidw_cmd_t;

  typedef struct packed {
    logic enable;
  } pidw_status_t;

endpackage
`default_nettype wire

@@ rtl/pidw_regs.sv @@
// Configuration register file of the PID controller with integral window
`timescale 1ns / 1ps
`default_nettype none
module pidw_regs
  import pidw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [30:0] cfg_wdata,
  output pidw_cfg_t        cfg
);

  pidw_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp              <= 16'sd0;
      cfg_r.ki              <= 16'sd0;
      cfg_r.kd              <= 16'sd0;
      cfg_r.integral_window <= 31'd50;
      cfg_r.drive_max       <= 16'sd127;
      cfg_r.drive_min       <= -16'sd127;
      cfg_r.sensor_scale    <= 16'sd256;
      cfg_r.motor_scale     <= 16'sd256;
    end else if (cfg_we) begin
      unique case (pidw_cfg_idx_t'(cfg_addr))
        CFG_KP:           cfg_r.kp              <= cfg_wdata[15:0];
        CFG_KI:           cfg_r.ki              <= cfg_wdata[15:0];
        CFG_KD:           cfg_r.kd              <= cfg_wdata[15:0];
        CFG_WINDOW:       cfg_r.integral_window <= cfg_wdata;
        CFG_DRIVE_MAX:    cfg_r.drive_max       <= cfg_wdata[15:0];
        CFG_DRIVE_MIN:    cfg_r.drive_min       <= cfg_wdata[15:0];
        CFG_SENSOR_SCALE: cfg_r.sensor_scale    <= cfg_wdata[15:0];
        CFG_MOTOR_SCALE:  cfg_r.motor_scale     <= cfg_wdata[15:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/pidw_ctrl.sv @@
// Sequencer of the PID controller with integral window
`timescale 1ns / 1ps
`default_nettype none
module pidw_ctrl
  import pidw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  input  wire pidw_status_t status,
  output pidw_cmd_t   cmd
);

  pidw_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MUL_SCALE;
    cmd.acc_op    = ACC_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          if (status.enable) begin
            state_nxt = ST_SCALE;
          end else begin
            cmd.clr_state = 1'b1;
            state_nxt     = ST_OUT;
          end
        end
      end
      ST_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SCALE;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.ld_err = 1'b1;
        cmd.acc_op = ACC_CLEAR;
        state_nxt  = ST_PROP;
      end
      ST_PROP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PROP;
        state_nxt   = ST_DERIV;
      end
      ST_DERIV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DERIV;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_INT_LO;
      end
      ST_INT_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INT_LO;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_INT_HI;
      end
      ST_INT_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INT_HI;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.ld_drive = 1'b1;
        state_nxt    = ST_MOTOR;
      end
      ST_MOTOR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MOTOR;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/pidw_datapath.sv @@
// Datapath of the PID controller with integral window: one shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module pidw_datapath
  import pidw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire pidw_cfg_t cfg,
  input  wire pidw_cmd_t cmd,
  input  wire pidw_in_t  in_data,
  output pidw_out_t out_data
);

  localparam logic signed [31:0] Max32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Min32 = 32'sh8000_0000;
  localparam logic signed [47:0] Max48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Min48 = 48'sh8000_0000_0000;
  localparam logic signed [15:0] Max16 = 16'sh7FFF;
  localparam logic signed [15:0] Min16 = 16'sh8000;

  logic signed [31:0] sample_r;
  logic signed [31:0] setpoint_r;
  logic               en_r;
  logic signed [48:0] prod_r;
  logic signed [31:0] err_r;
  logic signed [31:0] prev_r;
  logic signed [47:0] sum_r;
  logic signed [32:0] deriv_r;
  logic signed [63:0] acc_r;
  logic signed [15:0] drive_r;
  pidw_out_t          out_r;

  logic signed [15:0] a_op;
  logic signed [32:0] b_op;
  logic signed [48:0] prod_nxt;

  logic signed [40:0] scaled_w;
  logic signed [31:0] scaled;
  logic signed [32:0] diff;
  logic signed [31:0] err_nxt;
  logic        [32:0] mag;
  logic               in_win;
  logic signed [48:0] sum_add;
  logic signed [47:0] sum_sat;
  logic signed [47:0] sum_nxt;
  logic signed [32:0] deriv_nxt;
  logic signed [63:0] acc_nxt;

  logic signed [55:0] acc_sh;
  logic signed [55:0] dmax_w;
  logic signed [55:0] dmin_w;
  logic signed [55:0] drive_hi;
  logic signed [55:0] drive_lo;

  logic signed [23:0] motor_w;
  logic signed [15:0] motor;

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SCALE: begin
        a_op = cfg.sensor_scale;
        b_op = $signed({sample_r[31], sample_r});
      end
      MUL_PROP: begin
        a_op = cfg.kp;
        b_op = $signed({err_r[31], err_r});
      end
      MUL_DERIV: begin
        a_op = cfg.kd;
        b_op = deriv_r;
      end
      MUL_INT_LO: begin
        a_op = cfg.ki;
        b_op = $signed({9'd0, sum_r[23:0]});
      end
      MUL_INT_HI: begin
        a_op = cfg.ki;
        b_op = $signed({{9{sum_r[47]}}, sum_r[47:24]});
      end
      MUL_MOTOR: begin
        a_op = cfg.motor_scale;
        b_op = $signed({{17{drive_r[15]}}, drive_r});
      end
      default: begin
        a_op = cfg.kp;
        b_op = deriv_r;
      end
    endcase
  end

  assign prod_nxt = a_op * b_op;

  // scaled sample, error, window test, integral and derivative
  always_comb begin
    scaled_w = prod_r[48:8];
    if (scaled_w[40:31] == {10{scaled_w[40]}}) begin
      scaled = scaled_w[31:0];
    end else begin
      scaled = scaled_w[40] ? Min32 : Max32;
    end
    diff = $signed({scaled[31], scaled}) - $signed({setpoint_r[31], setpoint_r});
    if (diff[32] == diff[31]) begin
      err_nxt = diff[31:0];
    end else begin
      err_nxt = diff[32] ? Min32 : Max32;
    end
    mag     = err_nxt[31] ? (33'd0 - {err_nxt[31], err_nxt}) : {1'b0, err_nxt};
    in_win  = mag < {2'd0, cfg.integral_window};
    sum_add = $signed({sum_r[47], sum_r}) + $signed({{17{err_nxt[31]}}, err_nxt});
    if (sum_add[48] == sum_add[47]) begin
      sum_sat = sum_add[47:0];
    end else begin
      sum_sat = sum_add[48] ? Min48 : Max48;
    end
    sum_nxt   = ((cfg.ki != 16'sd0) && in_win) ? sum_sat : 48'sd0;
    deriv_nxt = $signed({err_nxt[31], err_nxt}) - $signed({prev_r[31], prev_r});
  end

  always_comb begin
    unique case (cmd.acc_op)
      ACC_HOLD:   acc_nxt = acc_r;
      ACC_CLEAR:  acc_nxt = 64'sd0;
      ACC_ADD:    acc_nxt = acc_r + $signed({{15{prod_r[48]}}, prod_r});
      ACC_ADD_HI: acc_nxt = acc_r + $signed({prod_r[39:0], 24'd0});
      default:    acc_nxt = acc_r;
    endcase
  end

  // upper clamp first, lower clamp wins when the limits cross
  always_comb begin
    acc_sh   = acc_r[63:8];
    dmax_w   = $signed({{40{cfg.drive_max[15]}}, cfg.drive_max});
    dmin_w   = $signed({{40{cfg.drive_min[15]}}, cfg.drive_min});
    drive_hi = (acc_sh > dmax_w) ? dmax_w : acc_sh;
    drive_lo = (drive_hi < dmin_w) ? dmin_w : drive_hi;
  end

  always_comb begin
    motor_w = prod_r[31:8];
    if (motor_w[23:15] == {9{motor_w[23]}}) begin
      motor = motor_w[15:0];
    end else begin
      motor = motor_w[23] ? Min16 : Max16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 32'sd0;
      sum_r  <= 48'sd0;
    end else if (cmd.clr_state) begin
      prev_r <= 32'sd0;
      sum_r  <= 48'sd0;
    end else if (cmd.ld_err) begin
      prev_r <= err_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      sample_r   <= in_data.sample;
      setpoint_r <= in_data.setpoint;
      en_r       <= in_data.enable;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.ld_err) begin
      err_r   <= err_nxt;
      deriv_r <= deriv_nxt;
    end
    acc_r <= acc_nxt;
    if (cmd.ld_drive) begin
      drive_r <= drive_lo[15:0];
    end
    if (cmd.ld_out) begin
      out_r.motor_drive <= en_r ? motor : 16'sd0;
      out_r.error_value <= en_r ? err_r : 32'sd0;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

@@ rtl/pid_with_integral_window.sv @@
// Top level of the PID controller with integral window
//
//   channel  direction  handshake                payload
//   in       input      in_valid / in_ready      pidw_in_t  (sample, setpoint, enable)
//   out      output     out_valid / out_ready    pidw_out_t (motor_drive, error_value)
//   cfg      input      cfg_we                   cfg_addr (3 bits), cfg_wdata (31 bits)
//
// An enabled beat runs six products one after another through a single 16 x 33
// multiplier, plus error, sum, clamp and output steps. A disabled beat goes from
// accept straight to its output step.
// Synchronous active-low reset; loop state, sequencer and config reset at once, no sweep.
// The output register holds a result while out_ready is low; a new beat is taken
// meanwhile and waits in its output step until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_with_integral_window_assert.svh"
module pid_with_integral_window
  import pidw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pidw_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output pidw_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [30:0] cfg_wdata
);

  pidw_cfg_t    cfg;
  pidw_cmd_t    cmd;
  pidw_status_t status;

  assign status.enable = in_data.enable;

  pidw_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pidw_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  `PIDW_ASSERT_NEXT(a_one_beat_at_a_time, in_valid && in_ready, !in_ready)
  `PIDW_ASSERT_NEXT(a_disabled_gives_zero,
                    in_valid && in_ready && !in_data.enable && !out_valid,
                    ##1 (out_valid && out_data == '0))
  `PIDW_ASSERT_NOW(a_result_only_when_busy, $rose(out_valid), !$past(in_ready))

endmodule
`default_nettype wire

@@ test/pid_with_integral_window_tb.sv @@
// Testbench for the PID controller with integral window: predicted commands vs. DUT beats
`timescale 1ns / 1ps
module pid_with_integral_window_tb
  import pidw_pkg::*;
;

  localparam longint SAT32_HI = 64'sd2147483647;
  localparam longint SAT32_LO = -64'sd2147483648;
  localparam longint SAT48_HI = 64'sd140737488355327;
  localparam longint SAT48_LO = -64'sd140737488355328;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES = 16;
  localparam int SOAK_TICKS = 20;

  class pid_tick_scoreboard;
    pidw_cfg_t regs;
    longint last_err;
    longint err_integral;
    pidw_out_t predicted_q[$];
    int fails;

    function new();
      regs.kp = 16'sd0;
      regs.ki = 16'sd0;
      regs.kd = 16'sd0;
      regs.integral_window = 31'd50;
      regs.drive_max = 16'sd127;
      regs.drive_min = -16'sd127;
      regs.sensor_scale = 16'sd256;
      regs.motor_scale = 16'sd256;
      last_err = 0;
      err_integral = 0;
      fails = 0;
    endfunction

    function void set_reg(pidw_cfg_idx_t idx, logic [30:0] val);
      case (idx)
        CFG_KP:           regs.kp = val[15:0];
        CFG_KI:           regs.ki = val[15:0];
        CFG_KD:           regs.kd = val[15:0];
        CFG_WINDOW:       regs.integral_window = val;
        CFG_DRIVE_MAX:    regs.drive_max = val[15:0];
        CFG_DRIVE_MIN:    regs.drive_min = val[15:0];
        CFG_SENSOR_SCALE: regs.sensor_scale = val[15:0];
        CFG_MOTOR_SCALE:  regs.motor_scale = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function void take_tick(pidw_in_t t);
      longint scaled, err, mag, acc, drive, motor;
      longint kp, ki, kd, dmax, dmin;
      pidw_out_t cmd;
      cmd = '0;
      if (!t.enable) begin
        last_err = 0;
        err_integral = 0;
      end else begin
        kp = longint'($signed(regs.kp));
        ki = longint'($signed(regs.ki));
        kd = longint'($signed(regs.kd));
        dmax = longint'($signed(regs.drive_max));
        dmin = longint'($signed(regs.drive_min));
        scaled = clip((longint'($signed(t.sample)) * longint'($signed(regs.sensor_scale)))
                      >>> 8, SAT32_LO, SAT32_HI);
        err = clip(scaled - longint'($signed(t.setpoint)), SAT32_LO, SAT32_HI);
        mag = (err < 0) ? -err : err;
        if (ki != 0 && mag < longint'({1'b0, regs.integral_window}))
          err_integral = clip(err_integral + err, SAT48_LO, SAT48_HI);
        else
          err_integral = 0;
        acc = kp * err + ki * err_integral + kd * (err - last_err);
        last_err = err;
        drive = acc >>> 8;
        if (drive > dmax) drive = dmax;
        if (drive < dmin) drive = dmin;
        motor = clip((drive * longint'($signed(regs.motor_scale))) >>> 8, -64'sd32768,
                     64'sd32767);
        cmd.motor_drive = motor[15:0];
        cmd.error_value = err[31:0];
      end
      predicted_q.push_back(cmd);
    endfunction

    task flag(string what);
      if (fails < 100) $display("pid tb: %s", what);
      fails++;
    endtask

    task check_cmd(pidw_out_t got);
      pidw_out_t want;
      if (predicted_q.size() == 0) begin
        flag($sformatf("unpredicted beat motor_drive=%0d error_value=%0d",
                       got.motor_drive, got.error_value));
        return;
      end
      want = predicted_q.pop_front();
      if (got.motor_drive !== want.motor_drive)
        flag($sformatf("motor_drive %0d, predicted %0d", got.motor_drive, want.motor_drive));
      if (got.error_value !== want.error_value)
        flag($sformatf("error_value %0d, predicted %0d", got.error_value, want.error_value));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pidw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pidw_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [30:0] cfg_wdata = '0;

  pid_tick_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_off = 1'b0;
  int quiet_cycles = 0;

  pid_with_integral_window u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_tick(in_data);
      if (out_valid && out_ready) sb.check_cmd(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  function automatic pidw_in_t mk_tick(logic [31:0] s, logic [31:0] sp, logic en);
    pidw_in_t t;
    t.sample = s;
    t.setpoint = sp;
    t.enable = en;
    return t;
  endfunction

  function automatic logic [31:0] pick_rail32();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] pick_near32();
    return 32'(int'($urandom_range(1024)) - 512);
  endfunction

  function automatic pidw_in_t rand_tick();
    pidw_in_t t;
    case ($urandom_range(9))
      0: begin
        t.sample = $urandom;
        t.setpoint = $urandom;
      end
      1: begin
        t.sample = pick_rail32();
        t.setpoint = pick_rail32();
      end
      default: begin
        t.sample = pick_near32();
        t.setpoint = pick_near32();
      end
    endcase
    t.enable = ($urandom_range(15) != 0);
    return t;
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return 256;
      default: return int'($urandom_range(2048)) - 1024;
    endcase
  endfunction

  function automatic int pick_window();
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return 50;
      3: return 32'h7fff_ffff;
      default: return $urandom_range(4000);
    endcase
  endfunction

  task automatic send_tick(pidw_in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pidw_cfg_idx_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(int kp, int ki, int kd, int win, int dmax, int dmin, int ss,
                              int ms);
    write_reg(CFG_KP, {15'($urandom), 16'(kp)});
    write_reg(CFG_KI, {15'($urandom), 16'(ki)});
    write_reg(CFG_KD, {15'($urandom), 16'(kd)});
    write_reg(CFG_WINDOW, 31'(win));
    write_reg(CFG_DRIVE_MAX, {15'($urandom), 16'(dmax)});
    write_reg(CFG_DRIVE_MIN, {15'($urandom), 16'(dmin)});
    write_reg(CFG_SENSOR_SCALE, {15'($urandom), 16'(ss)});
    write_reg(CFG_MOTOR_SCALE, {15'($urandom), 16'(ms)});
    cfg_we <= 1'b0;
  endtask

  task automatic run_ticks(int n, int gap, int stall);
    idle_pct = gap;
    stall_pct <= stall;
    repeat (n) send_tick(rand_tick());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(mk_tick(1000, 37, 1'b1));
    send_tick(mk_tick(32'h8000_0000, 32'h7fff_ffff, 1'b1));
    settle();

    program_regs(256, 256, 256, 100, 32767, -32768, 256, 256);
    send_tick(mk_tick(0, 0, 1'b1));
    send_tick(mk_tick(40, 0, 1'b1));
    send_tick(mk_tick(-99, 0, 1'b1));
    send_tick(mk_tick(100, 0, 1'b1));
    send_tick(mk_tick(0, 100, 1'b1));
    send_tick(mk_tick(99, 0, 1'b1));
    send_tick(mk_tick(10, 0, 1'b0));
    send_tick(mk_tick(32'h7fff_ffff, 32'h8000_0000, 1'b1));
    send_tick(mk_tick(32'h8000_0000, 32'h7fff_ffff, 1'b1));
    send_tick(mk_tick(32'h8000_0000, 0, 1'b1));
    send_tick(mk_tick(32'h7fff_ffff, -1, 1'b1));
    settle();

    program_regs(32767, -32768, -32768, 0, -100, 100, -32768, 32767);
    send_tick(mk_tick(32'h8000_0000, 0, 1'b1));
    send_tick(mk_tick(32'h7fff_ffff, 0, 1'b1));
    send_tick(mk_tick(1, 0, 1'b1));
    send_tick(mk_tick(-1, 32'h7fff_ffff, 1'b1));
    send_tick(mk_tick(255, 0, 1'b1));
    send_tick(mk_tick(0, 0, 1'b0));
    settle();

    program_regs(32767, 32767, 32767, 32'h7fff_ffff, 32767, -32768, 32767, 32767);
    run_ticks(150, 0, 0);
    settle();
    program_regs(-32768, -32768, -32768, 0, -32768, 32767, -32768, -32768);
    run_ticks(150, 70, 0);
    settle();
    for (int p = 2; p < 8; p++) begin
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_window(), pick_gain(),
                   pick_gain(), pick_gain(), pick_gain());
      case (p % 4)
        0: run_ticks(150, 0, 0);
        1: run_ticks(150, 70, 0);
        2: run_ticks(150, 0, 70);
        default: run_ticks(150, 12, 12);
      endcase
      settle();
    end

    program_regs(300, 40, -200, 2000, 20000, -20000, 256, 512);
    idle_pct = 0;
    stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (40) send_tick(rand_tick());
    join
    settle();

    // build up a large integral at the widest in-window error, then step back off it
    program_regs(0, -32768, 0, 32'h7fff_ffff, 32767, -32768, 256, 256);
    repeat (SOAK_TICKS) send_tick(mk_tick(32'h7fff_fffe, 0, 1'b1));
    send_tick(mk_tick(-5, 0, 1'b1));
    send_tick(mk_tick(-5, 0, 1'b1));
    settle();

    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
